// ===== rtl/core/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared opcodes, status codes and the control bundle that travels with each
// transaction through the divider pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // Operation codes carried in the request tuser field.
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MIN = 4'd4,
        OP_MAX = 4'd5,
        OP_INC = 4'd6,
        OP_DEC = 4'd7,
        OP_I2F = 4'd8,
        OP_F2I = 4'd9
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } t_status;

    // Width of the division numerator and the quotient bits resolved.
    localparam int NUM_W = 64;
    localparam int DEN_W = 33;
    localparam int QUO_W = 33;

    // Control and partial result that ride along with each transaction.
    typedef struct packed {
        t_op         op;
        logic [31:0] res;
        t_status     st;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        neg;
        logic        ovf;
        logic        dz;
    } t_side;

endpackage

// ===== rtl/core/fixed_point_q24_8_alu_top.sv =====
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU
// Signed fixed-point add, subtract, inc, dec, multiply, divide, min, max and
// conversions with saturation; multiply and divide round half away from zero.
// ----------------------------------------------------------------------------
// The ALU accepts one request per clock while the output is not stalled and
// returns each result in order: three operand and rounding stages, 33
// divider stages that each resolve one quotient bit, and the output register.
// Every operation runs through the same pipeline. The whole pipeline
// advances when the output register is empty or its transaction is taken,
// so s_tready follows m_tready combinationally.
module fixed_point_q24_8_alu_top #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  s_tuser,   // req_type [3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result_raw [31:0], status [33:32],
                                   // a_less [34], a_equal [35],
                                   // a_greater [36], zero fill [39:37]
);
    import fpa_pkg::*;

    localparam logic [63:0] HALF    = 64'(1) << (FRAC_BITS - 1);
    localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;

    logic en;

    // Stage A: registered request.
    logic        r_a_vld;
    t_op         r_a_op;
    logic [31:0] r_a_a;
    logic [31:0] r_a_b;

    // Stage B: simple results, magnitudes, product and division operands.
    logic               r_b_vld;
    t_side              r_b_side;
    logic [63:0]        r_b_prod;
    logic [NUM_W-1:0]   r_b_num;
    logic [DEN_W-1:0]   r_b_den;
    t_side              n_b_side;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
    logic [32:0]        sum;
    logic [32:0]        dif;
    logic [32:0]        inc;
    logic [32:0]        dec;
    logic [63:0]        i2f;

    // Stage C: multiply rounding and divider overflow check.
    logic               r_c_vld;
    t_side              r_c_side;
    logic [NUM_W-1:0]   r_c_num;
    logic [DEN_W-1:0]   r_c_den;
    t_side              n_c_side;
    logic [63:0]        mq;

    // Divider output and final stage.
    logic               d_vld;
    t_side              d_side;
    logic [QUO_W-1:0]   d_quo;
    logic               r_o_vld;
    logic [31:0]        r_o_res;
    t_status            r_o_st;
    logic               r_o_lt;
    logic               r_o_eq;
    logic               r_o_gt;
    logic [31:0]        n_o_res;
    t_status            n_o_st;

    // The pipeline moves when the output register can take a new value.
    assign en       = !r_o_vld || m_tready;
    assign s_tready = en;

    // Valid bits of the front stages and the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= s_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_o_vld <= d_vld;
        end
    end

    // Stage A payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_op <= t_op'(s_tuser);
            r_a_a  <= s_tdata[31:0];
            r_a_b  <= s_tdata[63:32];
        end
    end

    // Stage B: operations that finish here, and operands for the rest.
    always_comb begin
        mag_a = r_a_a[31] ? (~r_a_a + 32'd1) : r_a_a;
        mag_b = r_a_b[31] ? (~r_a_b + 32'd1) : r_a_b;
        sum   = {r_a_a[31], r_a_a} + {r_a_b[31], r_a_b};
        dif   = {r_a_a[31], r_a_a} - {r_a_b[31], r_a_b};
        inc   = {r_a_a[31], r_a_a} + 33'd1;
        dec   = {r_a_a[31], r_a_a} - 33'd1;
        i2f   = {{32{r_a_a[31]}}, r_a_a} << FRAC_BITS;

        n_b_side     = '0;
        n_b_side.op  = r_a_op;
        n_b_side.st  = ST_OK;
        n_b_side.lt  = $signed(r_a_a) <  $signed(r_a_b);
        n_b_side.eq  = r_a_a == r_a_b;
        n_b_side.gt  = $signed(r_a_a) >  $signed(r_a_b);
        n_b_side.neg = r_a_a[31] ^ r_a_b[31];

        case (r_a_op)
            OP_ADD: begin
                n_b_side.res = sum[31:0];
                if (sum[32] != sum[31]) begin
                    n_b_side.res = sum[32] ? MAX_NEG : MAX_POS;
                    n_b_side.st  = ST_SAT;
                end
            end
            OP_SUB: begin
                n_b_side.res = dif[31:0];
                if (dif[32] != dif[31]) begin
                    n_b_side.res = dif[32] ? MAX_NEG : MAX_POS;
                    n_b_side.st  = ST_SAT;
                end
            end
            OP_MIN: n_b_side.res = n_b_side.gt ? r_a_b : r_a_a;
            OP_MAX: n_b_side.res = n_b_side.gt ? r_a_a : r_a_b;
            OP_INC: begin
                n_b_side.res = inc[31:0];
                if (inc[32] != inc[31]) begin
                    n_b_side.res = MAX_POS;
                    n_b_side.st  = ST_SAT;
                end
            end
            OP_DEC: begin
                n_b_side.res = dec[31:0];
                if (dec[32] != dec[31]) begin
                    n_b_side.res = MAX_NEG;
                    n_b_side.st  = ST_SAT;
                end
            end
            OP_I2F: begin
                n_b_side.res = i2f[31:0];
                if (!(&i2f[63:31]) && (|i2f[63:31])) begin
                    n_b_side.res = i2f[63] ? MAX_NEG : MAX_POS;
                    n_b_side.st  = ST_SAT;
                end
            end
            OP_F2I: n_b_side.res = 32'($signed(r_a_a) >>> FRAC_BITS);
            default: n_b_side.res = '0;
        endcase
    end

    // Stage B payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side <= n_b_side;
            r_b_prod <= 64'(mag_a) * 64'(mag_b);
            r_b_num  <= (NUM_W'(mag_a) << (FRAC_BITS + 1)) + NUM_W'(mag_b);
            r_b_den  <= {mag_b, 1'b0};
        end
    end

    // Stage C: round the product and flag quotients beyond the divider range.
    always_comb begin
        mq       = (r_b_prod + HALF) >> FRAC_BITS;
        n_c_side = r_b_side;
        n_c_side.dz  = r_b_den == '0;
        n_c_side.ovf = {2'b00, r_b_num} >= {r_b_den, 33'd0};
        if (r_b_side.op == OP_MUL) begin
            if (r_b_side.neg ? (mq > 64'h8000_0000) : (mq > 64'h7fff_ffff)) begin
                n_c_side.res = r_b_side.neg ? MAX_NEG : MAX_POS;
                n_c_side.st  = ST_SAT;
            end else begin
                n_c_side.res = r_b_side.neg ? (~mq[31:0] + 32'd1) : mq[31:0];
            end
        end
    end

    // Stage C payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side <= n_c_side;
            r_c_num  <= r_b_num;
            r_c_den  <= r_b_den;
        end
    end

    fpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_side  (r_c_side),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .o_vld   (d_vld),
        .o_side  (d_side),
        .o_quo   (d_quo)
    );

    // Final stage: sign and saturate the quotient for divide requests.
    always_comb begin
        n_o_res = d_side.res;
        n_o_st  = d_side.st;
        if (d_side.op == OP_DIV) begin
            if (d_side.dz) begin
                n_o_res = '0;
                n_o_st  = ST_DIVZ;
            end else if (d_side.ovf ||
                         (d_side.neg ? (d_quo > 33'h0_8000_0000)
                                     : (d_quo > 33'h0_7fff_ffff))) begin
                n_o_res = d_side.neg ? MAX_NEG : MAX_POS;
                n_o_st  = ST_SAT;
            end else begin
                n_o_res = d_side.neg ? (~d_quo[31:0] + 32'd1) : d_quo[31:0];
                n_o_st  = ST_OK;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_res <= n_o_res;
            r_o_st  <= n_o_st;
            r_o_lt  <= d_side.lt;
            r_o_eq  <= d_side.eq;
            r_o_gt  <= d_side.gt;
        end
    end

    assign m_tvalid = r_o_vld;
    assign m_tdata  = {3'b000, r_o_gt, r_o_eq, r_o_lt, r_o_st, r_o_res};

    // Exactly one compare flag holds for every result.
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> $onehot({r_o_lt, r_o_eq, r_o_gt}))
        else $error("compare flags not one-hot");

    // A divide-by-zero result always carries a zero word.
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_st == ST_DIVZ) |-> (r_o_res == '0))
        else $error("divide by zero with nonzero result");

    // Saturated results sit on one of the two bounds.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_st == ST_SAT) |-> (r_o_res == MAX_POS || r_o_res == MAX_NEG))
        else $error("saturated result off the bounds");

    // A stalled output holds its transaction.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !m_tready) |=> (r_o_vld && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

// ===== rtl/core/fpa_div.sv =====
// ----------------------------------------------------------------------------
// Fixed-point ALU divider pipeline
// Restoring division, one quotient bit per register stage, most significant
// bit first. The side bundle travels alongside each transaction.
// ----------------------------------------------------------------------------
module fpa_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  fpa_pkg::t_side              i_side,
    input  logic [fpa_pkg::NUM_W-1:0]   i_num,
    input  logic [fpa_pkg::DEN_W-1:0]   i_den,
    output logic                        o_vld,
    output fpa_pkg::t_side              o_side,
    output logic [fpa_pkg::QUO_W-1:0]   o_quo
);
    import fpa_pkg::*;

    localparam int WW = NUM_W + 2;

    logic               r_vld  [QUO_W];
    t_side              r_side [QUO_W];
    logic [NUM_W-1:0]   r_rem  [QUO_W];
    logic [DEN_W-1:0]   r_den  [QUO_W];
    logic [QUO_W-1:0]   r_quo  [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            localparam int BIT = QUO_W - 1 - k;

            logic               p_vld;
            t_side              p_side;
            logic [NUM_W-1:0]   p_rem;
            logic [DEN_W-1:0]   p_den;
            logic [QUO_W-1:0]   p_quo;
            logic [WW-1:0]      shd;
            logic               ge;
            logic [NUM_W-1:0]   n_rem;
            logic [QUO_W-1:0]   n_quo;

            // Previous stage, or the pipeline input for the first one.
            if (k == 0) begin : g_first
                assign p_vld  = i_vld;
                assign p_side = i_side;
                assign p_rem  = i_num;
                assign p_den  = i_den;
                assign p_quo  = '0;
            end else begin : g_next
                assign p_vld  = r_vld[k-1];
                assign p_side = r_side[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_den  = r_den[k-1];
                assign p_quo  = r_quo[k-1];
            end

            // Trial subtract of the shifted divisor.
            always_comb begin
                shd   = WW'(p_den) << BIT;
                ge    = {2'b00, p_rem} >= shd;
                n_rem = ge ? NUM_W'({2'b00, p_rem} - shd) : p_rem;
                n_quo = p_quo;
                n_quo[BIT] = ge;
            end

            // Valid bit of the stage.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= p_vld;
                end
            end

            // Payload of the stage.
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side[k] <= p_side;
                    r_rem[k]  <= n_rem;
                    r_den[k]  <= p_den;
                    r_quo[k]  <= n_quo;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[QUO_W-1];
    assign o_side = r_side[QUO_W-1];
    assign o_quo  = r_quo[QUO_W-1];

endmodule
